### hw/rtl/aas_pkg.sv
package aas_pkg;

   // Field widths
   localparam int VALUE_WIDTH = 32;
   localparam int PROB_BITS   = 16;
   localparam int ITER_WIDTH  = 16;
   localparam int BETA_WIDTH  = 32;
   localparam int DRAW_WIDTH  = 16;
   localparam int PROB_WIDTH  = PROB_BITS + 1;

   // Register widths and indexes
   localparam int BSTART_WIDTH = 24;
   localparam int BMULT_WIDTH  = 27;
   localparam int MODE_WIDTH   = 2;
   localparam int CSR_WIDTH    = 27;
   localparam int CSR_ADDR_W   = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_BETA_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BETA_MULT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE       = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ITER_COUNT = 2'd3;

   localparam logic [MODE_WIDTH-1:0] MODE_GEOMETRIC   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_EXPONENTIAL = 2'd1;

   // Reset values of the registers
   localparam logic [BSTART_WIDTH-1:0] BSTART_RESET = 24'd15099494;
   localparam logic [BMULT_WIDTH-1:0]  BMULT_RESET  = 27'd17616077;
   localparam logic [ITER_WIDTH-1:0]   ITER_RESET   = 16'd200;

   // Fixed-point constants, Q.24
   localparam logic [24:0] Q24_ONE    = 25'd16777216;
   localparam logic [23:0] Q24_HALF   = 24'd8388608;
   localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
   localparam logic [23:0] LN2_Q24    = 24'd11629080;
   localparam logic [23:0] RSQRT2_Q24 = 24'd11863283;
   localparam logic [28:0] X_CUTOFF   = 29'd402653184;
   // ceil(2^32 / 3): floor(m / 3) = (m * RECIP3) >> 32 for m below 2^31
   localparam logic [31:0] RECIP3     = 32'd1431655766;

   // Rounding of the Q.24 result to PROB_BITS
   localparam int RND_SHIFT = 24 - PROB_BITS;
   localparam logic [25:0] RND_HALF = 26'((64'd1 << RND_SHIFT) >> 1);
   localparam logic [PROB_WIDTH-1:0] PROB_ONE = PROB_WIDTH'(64'd1 << PROB_BITS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_HI,
      S_LO,
      S_Y,
      S_U,
      S_T4,
      S_D3,
      S_T2,
      S_T1,
      S_HALF,
      S_RND,
      S_FIN,
      S_SCH1,
      S_SCH2
   } state_type;

endpackage

### hw/rtl/annealing_acceptance_step.sv
// Channel  Dir  Handshake                 Payload
// req_     in   req_tvalid / req_tready   tdata: loss, x, y, z, draw; tuser: start_req
// rsp_     out  rsp_tvalid / rsp_tready   tdata: step, prob, accepted, beta, kept point;
//                                          tlast: last
// csr_     in   csr_we                    csr_addr, csr_wdata
//
// One word is taken in S_IDLE only; a step then runs through one shared 32x32
// multiplier. The exponential is evaluated in S_HI through S_RND; a probability
// settled early goes straight to S_FIN, and a start word or a word dropped outside
// a run returns from S_LOAD to S_IDLE. The result sits in an output register,
// so the next word is taken while it waits; a step stalls at its finish only while
// the previous result is still untaken. Reset is synchronous and needs no clearing.
module annealing_acceptance_step
   import aas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] cand_loss, [63:32] cand_x, [95:64] cand_y, [127:96] cand_z,
   // [143:128] uniform_draw
   input  logic [143:0]          req_tdata,
   // [0] start_req
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] step_index, [32:16] accept_prob, [33] accepted, [65:34] beta_used,
   // [97:66] kept_loss, [129:98] kept_x, [161:130] kept_y, [193:162] kept_z,
   // [199:194] zero
   output logic [199:0]          rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_WIDTH-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   // Configuration
   logic [BSTART_WIDTH-1:0] bstart_ff;
   logic [BMULT_WIDTH-1:0]  bmult_ff;
   logic [MODE_WIDTH-1:0]   mode_ff;
   logic [ITER_WIDTH-1:0]   iter_cnt_ff;

   // Annealing state
   logic [BETA_WIDTH-1:0]  beta_ff, beta_in;
   logic [BETA_WIDTH-1:0]  factor_ff, factor_in;
   logic signed [VALUE_WIDTH-1:0] cur_loss_ff, cur_loss_in;
   logic signed [VALUE_WIDTH-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, cur_z_ff, cur_z_in;
   logic [ITER_WIDTH-1:0]  step_ff, step_in;
   logic                   active_ff, active_in;

   // Latched input word
   logic                          start_ff;
   logic signed [VALUE_WIDTH-1:0] cand_loss_ff, cand_x_ff, cand_y_ff, cand_z_ff;
   logic [DRAW_WIDTH-1:0]         draw_ff;

   // Working registers
   logic [63:0]           prod_ff;
   logic [31:0]           mul_a, mul_b;
   logic [28:0]           hi_ff, hi_in;
   logic [5:0]            n_ff, n_in;
   logic                  half_ff, half_in;
   logic [23:0]           u_ff, u_in;
   logic [24:0]           t_ff, t_in;
   logic [PROB_WIDTH-1:0] prob_ff, prob_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [199:0]          rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Helper signals
   logic                   req_take;
   logic                   rsp_free;
   logic                   prob_is_one;
   logic [VALUE_WIDTH:0]   diff;
   logic [31:0]            mag;
   logic                   hi_cut;
   logic [48:0]            x_sum;
   logic [32:0]            x_val;
   logic                   x_cut;
   logic [29:0]            y_val;
   logic [23:0]            f_val;
   logic [24:0]            r_val;
   logic [25:0]            p_rnd;
   logic [25:0]            p_val;
   logic                   acc;
   logic [ITER_WIDTH-1:0]  step_next;
   logic                   last;
   logic [39:0]            sat_src;
   logic [BETA_WIDTH-1:0]  sat_val;

   assign req_take = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Probability is one for a non-positive loss change or a zero beta
   assign diff        = {cand_loss_ff[VALUE_WIDTH-1], cand_loss_ff}
                      - {cur_loss_ff[VALUE_WIDTH-1], cur_loss_ff};
   assign mag         = diff[31:0];
   assign prob_is_one = (cand_loss_ff <= cur_loss_ff) || (beta_ff == '0);

   assign hi_cut = prod_ff[48:0] >= 49'(X_CUTOFF);
   assign x_sum  = {4'd0, hi_ff, 16'd0} + {1'b0, prod_ff[47:0]};
   assign x_val  = x_sum[48:16];
   assign x_cut  = x_val >= 33'(X_CUTOFF);
   assign y_val  = prod_ff[53:24];
   assign f_val  = y_val[23] ? {1'b0, y_val[22:0]} : y_val[23:0];

   // Scale down by the integer part and round to the probability width
   assign r_val = (n_ff >= 6'd32) ? 25'd0 : (t_ff >> n_ff[4:0]);
   assign p_rnd = {1'b0, r_val} + RND_HALF;
   assign p_val = p_rnd >> RND_SHIFT;

   assign acc       = {1'b0, draw_ff, {PROB_BITS{1'b0}}} < {prob_ff, {DRAW_WIDTH{1'b0}}};
   assign step_next = step_ff + 1'b1;
   assign last      = step_next == iter_cnt_ff;

   // Floor to Q8.24 and saturate
   assign sat_src = prod_ff[63:24];
   assign sat_val = (sat_src[39:32] != '0) ? '1 : sat_src[31:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_take) state_in = S_LOAD;
         S_LOAD: begin
            if (start_ff || !active_ff) state_in = S_IDLE;
            else if (prob_is_one)       state_in = S_FIN;
            else                        state_in = S_HI;
         end
         S_HI:   state_in = hi_cut ? S_FIN : S_LO;
         S_LO:   state_in = x_cut ? S_FIN : S_Y;
         S_Y:    state_in = S_U;
         S_U:    state_in = S_T4;
         S_T4:   state_in = S_D3;
         S_D3:   state_in = S_T2;
         S_T2:   state_in = S_T1;
         S_T1:   state_in = half_ff ? S_HALF : S_RND;
         S_HALF: state_in = S_RND;
         S_RND:  state_in = S_FIN;
         S_FIN: begin
            if (rsp_free) begin
               if (mode_ff inside {MODE_GEOMETRIC, MODE_EXPONENTIAL})
                  state_in = S_SCH1;
               else
                  state_in = S_IDLE;
            end
         end
         S_SCH1: state_in = (mode_ff == MODE_EXPONENTIAL) ? S_SCH2 : S_IDLE;
         S_SCH2: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Operands, datapath and state updates
   always_comb begin
      req_tready   = state_ff == S_IDLE;
      mul_a        = '0;
      mul_b        = '0;
      beta_in      = beta_ff;
      factor_in    = factor_ff;
      cur_loss_in  = cur_loss_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_z_in     = cur_z_ff;
      step_in      = step_ff;
      active_in    = active_ff;
      hi_in        = hi_ff;
      n_in         = n_ff;
      half_in      = half_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      prob_in      = prob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_LOAD: begin
            mul_a = beta_ff;
            mul_b = {16'd0, mag[31:16]};
            if (start_ff) begin
               beta_in     = {8'd0, bstart_ff};
               factor_in   = 32'(Q24_ONE);
               cur_loss_in = cand_loss_ff;
               cur_x_in    = cand_x_ff;
               cur_y_in    = cand_y_ff;
               cur_z_in    = cand_z_ff;
               step_in     = '0;
               active_in   = 1'b1;
            end else if (prob_is_one) begin
               prob_in = PROB_ONE;
            end
         end
         S_HI: begin
            hi_in = prod_ff[28:0];
            mul_a = beta_ff;
            mul_b = {16'd0, mag[15:0]};
            if (hi_cut) prob_in = '0;
         end
         S_LO: begin
            mul_a = x_val[31:0];
            mul_b = 32'(LOG2E_Q24);
            if (x_cut) prob_in = '0;
         end
         S_Y: begin
            n_in    = y_val[29:24];
            half_in = y_val[23];
            mul_a   = {8'd0, f_val};
            mul_b   = {8'd0, LN2_Q24};
         end
         S_U: begin
            // u * (1 - u/4)
            u_in  = prod_ff[47:24];
            mul_a = {8'd0, prod_ff[47:24]};
            mul_b = 32'(Q24_ONE - 25'(prod_ff[47:26]));
         end
         S_T4: begin
            mul_a = {7'd0, prod_ff[48:24]};
            mul_b = RECIP3;
         end
         S_D3: begin
            mul_a = {8'd0, u_ff};
            mul_b = 32'(Q24_ONE - 25'(prod_ff[56:32]));
         end
         S_T2: begin
            mul_a = {8'd0, u_ff};
            mul_b = 32'(Q24_ONE - 25'(prod_ff[48:25]));
         end
         S_T1: begin
            t_in  = Q24_ONE - prod_ff[48:24];
            mul_a = 32'(Q24_ONE - prod_ff[48:24]);
            mul_b = {8'd0, RSQRT2_Q24};
         end
         S_HALF: t_in = prod_ff[48:24];
         S_RND: begin
            prob_in = (p_val > 26'(PROB_ONE)) ? PROB_ONE : p_val[PROB_WIDTH-1:0];
         end
         S_FIN: begin
            mul_a = beta_ff;
            mul_b = (mode_ff == MODE_EXPONENTIAL) ? factor_ff : {5'd0, bmult_ff};
            if (rsp_free) begin
               // Commit the decision and emit the result word
               rsp_valid_in = 1'b1;
               rsp_last_in  = last;
               rsp_data_in  = {6'd0,
                               acc ? cand_z_ff    : cur_z_ff,
                               acc ? cand_y_ff    : cur_y_ff,
                               acc ? cand_x_ff    : cur_x_ff,
                               acc ? cand_loss_ff : cur_loss_ff,
                               beta_ff, acc, prob_ff, step_ff};
               if (acc) begin
                  cur_loss_in = cand_loss_ff;
                  cur_x_in    = cand_x_ff;
                  cur_y_in    = cand_y_ff;
                  cur_z_in    = cand_z_ff;
               end
               step_in = step_next;
               if (last) active_in = 1'b0;
            end
         end
         S_SCH1: begin
            beta_in = sat_val;
            mul_a   = factor_ff;
            mul_b   = {5'd0, bmult_ff};
         end
         S_SCH2: factor_in = sat_val;
         default: ;
      endcase
   end

   // Shared multiplier
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bstart_ff    <= BSTART_RESET;
         bmult_ff     <= BMULT_RESET;
         mode_ff      <= MODE_GEOMETRIC;
         iter_cnt_ff  <= ITER_RESET;
         beta_ff      <= {8'd0, BSTART_RESET};
         factor_ff    <= 32'(Q24_ONE);
         cur_loss_ff  <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_z_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         beta_ff      <= beta_in;
         factor_ff    <= factor_in;
         cur_loss_ff  <= cur_loss_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_z_ff     <= cur_z_in;
         step_ff      <= step_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_BETA_START: bstart_ff   <= csr_wdata[BSTART_WIDTH-1:0];
               CSR_BETA_MULT:  bmult_ff    <= csr_wdata[BMULT_WIDTH-1:0];
               CSR_MODE:       mode_ff     <= csr_wdata[MODE_WIDTH-1:0];
               CSR_ITER_COUNT: iter_cnt_ff <= csr_wdata[ITER_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff     <= req_tuser;
         cand_loss_ff <= req_tdata[31:0];
         cand_x_ff    <= req_tdata[63:32];
         cand_y_ff    <= req_tdata[95:64];
         cand_z_ff    <= req_tdata[127:96];
         draw_ff      <= req_tdata[143:128];
      end
      hi_ff       <= hi_in;
      n_ff        <= n_in;
      half_ff     <= half_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      prob_ff     <= prob_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/sv/tb_annealing_acceptance_step.sv
module tb_annealing_acceptance_step
   import aas_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected result word
   typedef struct packed {
      logic [15:0]            step_index;
      logic [PROB_WIDTH-1:0]  accept_prob;
      logic                   accepted;
      logic [31:0]            beta_used;
      logic [31:0]            kept_loss;
      logic [31:0]            kept_x;
      logic [31:0]            kept_y;
      logic [31:0]            kept_z;
      logic                   last;
   } step_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Predicts each step of the annealing run and holds pending results
   class scoreboard_type;
      logic [23:0] beta_start_reg;
      logic [26:0] beta_mult_reg;
      logic [1:0]  mode_reg;
      logic [15:0] iter_count_reg;
      logic [63:0] beta_now;
      logic [63:0] factor_power;
      logic [31:0] cur_loss;
      logic [31:0] cur_x, cur_y, cur_z;
      logic [15:0] step_count;
      bit          run_active;
      step_result_type pending_steps[$];

      function new();
         beta_start_reg = BSTART_RESET;
         beta_mult_reg = BMULT_RESET;
         mode_reg = MODE_GEOMETRIC;
         iter_count_reg = ITER_RESET;
         beta_now = 64'(BSTART_RESET);
         factor_power = 64'd16777216;
         cur_loss = '0;
         cur_x = '0;
         cur_y = '0;
         cur_z = '0;
         step_count = '0;
         run_active = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_WIDTH-1:0] data);
         case (addr)
            CSR_BETA_START: beta_start_reg = data[23:0];
            CSR_BETA_MULT:  beta_mult_reg = data[26:0];
            CSR_MODE:       mode_reg = data[1:0];
            default:        iter_count_reg = data[15:0];
         endcase
      endfunction

      function logic [63:0] mul_q24_sat(logic [63:0] a, logic [63:0] b);
         logic [63:0] p;
         p = (a * b) >> 24;
         return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
      endfunction

      function logic [63:0] exp_negative(logic [63:0] x24);
         logic [63:0] y, n, f, u, t;
         bit half;
         y = (x24 * 64'd24204406) >> 24;
         n = y >> 24;
         f = y & 64'hFF_FFFF;
         half = f >= 64'd8388608;
         if (half) f = f - 64'd8388608;
         u = (f * 64'd11629080) >> 24;
         t = 64'd16777216 - (u >> 2);
         t = 64'd16777216 - ((u * t) >> 24) / 3;
         t = 64'd16777216 - ((u * t) >> 24) / 2;
         t = 64'd16777216 - ((u * t) >> 24);
         if (half) t = (t * 64'd11863283) >> 24;
         if (n >= 32) return 0;
         return t >> n;
      endfunction

      function logic [63:0] acceptance(logic signed [31:0] cand, logic signed [31:0] cur,
                                       logic [63:0] beta);
         logic [63:0] one, mag, dh, dl, hi, x24, r, p;
         one = 64'd1 << PROB_BITS;
         if (cand <= cur || beta == 0) return one;
         mag = 64'($signed(cand)) - 64'($signed(cur));
         dh = mag >> 16;
         dl = mag & 64'hFFFF;
         if (dh > 64'hFFFF_FFFF) return 0;
         hi = beta * dh;
         if (hi >= (64'd24 << 24)) return 0;
         x24 = ((hi << 16) + beta * dl) >> 16;
         if (x24 >= (64'd24 << 24)) return 0;
         r = exp_negative(x24);
         p = (r + ((64'd1 << (24 - PROB_BITS)) >> 1)) >> (24 - PROB_BITS);
         return (p > one) ? one : p;
      endfunction

      // Note one accepted input word
      function void note_input(logic start, logic [31:0] loss, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z, logic [15:0] draw);
         step_result_type r;
         logic [63:0] prob;
         logic [15:0] nxt;
         if (start) begin
            beta_now = 64'(beta_start_reg);
            factor_power = 64'd16777216;
            cur_loss = loss;
            cur_x = x;
            cur_y = y;
            cur_z = z;
            step_count = '0;
            run_active = 1;
            return;
         end
         if (!run_active) return;
         prob = acceptance(loss, cur_loss, beta_now);
         r.accepted = (64'(draw) << PROB_BITS) < (prob << 16);
         if (r.accepted) begin
            cur_loss = loss;
            cur_x = x;
            cur_y = y;
            cur_z = z;
         end
         nxt = step_count + 16'd1;
         r.step_index = step_count;
         r.accept_prob = prob[PROB_WIDTH-1:0];
         r.beta_used = beta_now[31:0];
         r.kept_loss = cur_loss;
         r.kept_x = cur_x;
         r.kept_y = cur_y;
         r.kept_z = cur_z;
         r.last = nxt == iter_count_reg;
         pending_steps.insert(pending_steps.size(), r);
         if (mode_reg == MODE_GEOMETRIC) begin
            beta_now = mul_q24_sat(beta_now, 64'(beta_mult_reg));
         end else if (mode_reg == MODE_EXPONENTIAL) begin
            beta_now = mul_q24_sat(beta_now, factor_power);
            factor_power = mul_q24_sat(factor_power, 64'(beta_mult_reg));
         end
         step_count = nxt;
         if (r.last) run_active = 0;
      endfunction

      // Check one result word against the oldest expectation
      task check_result(logic [199:0] data, logic tlast);
         step_result_type w;
         if (pending_steps.size() == 0) begin
            report_mismatch("unexpected result", data[63:0], 0);
            return;
         end
         w = pending_steps.pop_front();
         if (data[15:0] !== w.step_index) report_mismatch("step_index", data[15:0], w.step_index);
         if (data[32:16] !== w.accept_prob)
            report_mismatch("accept_prob", data[32:16], w.accept_prob);
         if (data[33] !== w.accepted) report_mismatch("accepted", data[33], w.accepted);
         if (data[65:34] !== w.beta_used) report_mismatch("beta_used", data[65:34], w.beta_used);
         if (data[97:66] !== w.kept_loss) report_mismatch("kept_loss", data[97:66], w.kept_loss);
         if (data[129:98] !== w.kept_x) report_mismatch("kept_x", data[129:98], w.kept_x);
         if (data[161:130] !== w.kept_y) report_mismatch("kept_y", data[161:130], w.kept_y);
         if (data[193:162] !== w.kept_z) report_mismatch("kept_z", data[193:162], w.kept_z);
         if (data[199:194] !== 6'd0) report_mismatch("pad", data[199:194], 0);
         if (tlast !== w.last) report_mismatch("last", tlast, w.last);
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [143:0]          req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [199:0]          rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_WIDTH-1:0]  csr_wdata = '0;

   scoreboard_type step_board = new();
   bit long_hold = 0;

   annealing_acceptance_step dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: stall on a changing pattern, with one long hold-off
   initial begin
      int mode;
      int phase;
      mode = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) step_board.check_result(rsp_tdata, rsp_tlast);
         phase++;
         if (phase % 300 == 0) mode = $urandom_range(0, 3);
         if (long_hold) rsp_tready <= 0;
         else case (mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (phase % 7) < 3;
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   initial begin
      repeat (3000) @(posedge clock);
      long_hold = 1;
      repeat (600) @(posedge clock);
      long_hold = 0;
   end

   // Write one register, then drop the write enable again
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_WIDTH-1:0] d);
      csr_we <= 1;
      csr_addr <= addr;
      csr_wdata <= d;
      @(posedge clock);
      step_board.write_reg(addr, d);
      csr_we <= 0;
      @(posedge clock);
   endtask

   // Offer one word and hold it until taken
   task automatic send_word(input logic start, input logic [31:0] loss, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z, input logic [15:0] draw);
      req_tvalid <= 1;
      req_tuser <= start;
      req_tdata <= {draw, z, y, x, loss};
      do @(posedge clock); while (!req_tready);
      step_board.note_input(start, loss, x, y, z, draw);
   endtask

   task automatic gap(input int n);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (step_board.pending_steps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] near_loss(logic [31:0] base);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return base - $urandom_range(0, 65536);
         default: return base + $urandom_range(0, 1 << $urandom_range(4, 22));
      endcase
   endfunction

   // Run of random steps with small losses around the kept one
   task automatic random_run(input int steps, input int ignored);
      logic [31:0] loss;
      int burst;
      burst = 0;
      loss = $urandom;
      send_word(1, loss, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < steps; i++) begin
         if (burst == 0) begin
            gap($urandom_range(0, 1) ? $urandom_range(1, 12) : 0);
            burst = $urandom_range(1, 20);
         end
         burst--;
         if ($urandom_range(0, 40) == 0)
            send_word(0, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            send_word(0, near_loss(step_board.cur_loss), $urandom, $urandom, $urandom,
                      $urandom);
      end
      for (int i = 0; i < ignored; i++)
         send_word(0, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int done;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: word outside a run, extremes of fields and of beta
      send_word(0, 32'h7FFF_FFFF, 0, 0, 0, 16'hFFFF);
      write_csr(CSR_ITER_COUNT, 6);
      send_word(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
      send_word(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000, 16'd0);
      send_word(0, 32'h8000_0000, 1, 2, 3, 16'hFFFF);
      send_word(0, 32'h0000_0001, 4, 5, 6, 16'hFFFF);
      send_word(0, 32'h0000_4000, 7, 8, 9, 16'h8000);
      send_word(1, 32'h0001_0000, 1, 1, 1, 16'h1234);
      send_word(0, 32'h0001_8000, 2, 2, 2, 16'h0000);
      send_word(0, 32'h0001_8000, 3, 3, 3, 16'hFFFF);
      drain();
      write_csr(CSR_BETA_START, 0);
      write_csr(CSR_MODE, 2'd3);
      write_csr(CSR_ITER_COUNT, 2);
      random_run(2, 2);
      drain();
      write_csr(CSR_BETA_START, 24'hFF_FFFF);
      write_csr(CSR_BETA_MULT, 27'h400_0000);
      write_csr(CSR_MODE, MODE_EXPONENTIAL);
      write_csr(CSR_ITER_COUNT, 40);
      random_run(40, 1);
      drain();

      // Random phases over several settings
      done = 0;
      while (done < 1050) begin
         write_csr(CSR_BETA_START, $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 24'hFF_FFFF));
         write_csr(CSR_BETA_MULT, $urandom_range(0, 3) == 0 ? 27'd16777217 :
                   $urandom_range(16777217, 67108864));
         write_csr(CSR_MODE, $urandom_range(0, 3));
         write_csr(CSR_ITER_COUNT, $urandom_range(0, 9) == 0 ? 16'd1 : $urandom_range(5, 120));
         begin
            int n;
            n = step_board.iter_count_reg;
            if ($urandom_range(0, 3) == 0) n = n / 2 + 1;
            random_run(n, $urandom_range(0, 2));
            done += n + 1;
         end
         drain();
      end
      // Counter wrap: a zero count means a full 2^16 step run; only its first 30 steps are sent
      write_csr(CSR_ITER_COUNT, 0);
      random_run(30, 0);
      drain();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### annealing_acceptance_step.f
hw/rtl/aas_pkg.sv
hw/rtl/annealing_acceptance_step.sv
tb/sv/tb_annealing_acceptance_step.sv
